FILE: src/tlvx_pkg.sv
// ----------------------------------------------------------------------------
// tlvx_pkg: shared types and constants of the TLV tag extractor
// Record phases, status codes, register map and the structs passed between
// the register file, the record parser and the top level.
// ----------------------------------------------------------------------------
package tlvx_pkg;

   localparam int unsigned CSR_ADDR_W = 6;
   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned TAG_W      = 8;
   localparam int unsigned LEN_W      = 16;
   localparam int unsigned NUM_TAGS   = 256;
   localparam int unsigned BANK_W     = 64;
   localparam int unsigned NUM_BANKS  = NUM_TAGS / BANK_W;

   typedef enum logic [2:0] {
      PH_TAG,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_VALUE,
      PH_IGNORE
   } tlvx_phase_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_INVALID,
      ST_NOT_FOUND,
      ST_TRUNCATED
   } tlvx_status_type;

   typedef enum logic [2:0] {
      REG_TARGET_TAG,
      REG_VALID_TAGS_0_63,
      REG_VALID_TAGS_64_127,
      REG_VALID_TAGS_128_191,
      REG_VALID_TAGS_192_255
   } tlvx_reg_type;

   typedef struct packed {
      logic [TAG_W-1:0]    target_tag;
      logic [NUM_TAGS-1:0] valid_tags;
   } tlvx_cfg_type;

   typedef struct packed {
      logic [7:0]      value_byte;
      logic            has_byte;
      logic            done_res;
      tlvx_status_type status;
   } tlvx_result_type;

endpackage

FILE: src/tlvx_csr.sv
// ----------------------------------------------------------------------------
// tlvx_csr: configuration registers
// Target tag and the 256-bit valid-tag set, written and read over APB.
// ----------------------------------------------------------------------------
module tlvx_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tlvx_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [tlvx_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [tlvx_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output tlvx_pkg::tlvx_cfg_type              cfg
);
   import tlvx_pkg::*;

   logic [TAG_W-1:0]                   target_tag_ff;
   logic [TAG_W-1:0]                   target_tag_in;
   logic [NUM_BANKS-1:0][BANK_W-1:0]   valid_tags_ff;
   logic [NUM_BANKS-1:0][BANK_W-1:0]   valid_tags_in;
   logic                               wr_en;
   tlvx_reg_type                       reg_idx;

   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = tlvx_reg_type'(csr_paddr[5:3]);
   assign csr_pready = 1'b1;

   always_comb begin
      target_tag_in = target_tag_ff;
      valid_tags_in = valid_tags_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_TARGET_TAG:         target_tag_in    = csr_pwdata[TAG_W-1:0];
            REG_VALID_TAGS_0_63:    valid_tags_in[0] = csr_pwdata;
            REG_VALID_TAGS_64_127:  valid_tags_in[1] = csr_pwdata;
            REG_VALID_TAGS_128_191: valid_tags_in[2] = csr_pwdata;
            REG_VALID_TAGS_192_255: valid_tags_in[3] = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_TARGET_TAG:         csr_prdata = {{(CSR_DATA_W-TAG_W){1'b0}}, target_tag_ff};
         REG_VALID_TAGS_0_63:    csr_prdata = valid_tags_ff[0];
         REG_VALID_TAGS_64_127:  csr_prdata = valid_tags_ff[1];
         REG_VALID_TAGS_128_191: csr_prdata = valid_tags_ff[2];
         REG_VALID_TAGS_192_255: csr_prdata = valid_tags_ff[3];
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_tag_ff <= '0;
         valid_tags_ff <= '0;
      end else begin
         target_tag_ff <= target_tag_in;
         valid_tags_ff <= valid_tags_in;
      end
   end

   assign cfg.target_tag = target_tag_ff;
   assign cfg.valid_tags = valid_tags_ff;

endmodule

FILE: src/tlvx_parse.sv
// ----------------------------------------------------------------------------
// tlvx_parse: record parser
// Per-byte phase machine over tag, length and value bytes; builds the result.
// ----------------------------------------------------------------------------
module tlvx_parse (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step_en,
   input  logic [7:0]                        stream_byte,
   input  logic                              end_of_buffer,
   input  tlvx_pkg::tlvx_cfg_type            cfg,
   output logic                              res_valid,
   output tlvx_pkg::tlvx_result_type         res
);
   import tlvx_pkg::*;

   tlvx_phase_type      phase_ff;
   tlvx_phase_type      phase_in;
   logic [7:0]          length_high_ff;
   logic [7:0]          length_high_in;
   logic [LEN_W-1:0]    bytes_left_ff;
   logic [LEN_W-1:0]    bytes_left_in;
   logic                record_matches_ff;
   logic                record_matches_in;
   logic                tag_ok;
   logic [LEN_W-1:0]    len;
   logic [LEN_W-1:0]    left_dec;
   logic                rearm;

   assign tag_ok   = cfg.valid_tags[stream_byte];
   assign len      = {length_high_ff, stream_byte};
   assign left_dec = bytes_left_ff - LEN_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_TAG;
         length_high_ff    <= '0;
         bytes_left_ff     <= '0;
         record_matches_ff <= 1'b0;
      end else begin
         phase_ff          <= phase_in;
         length_high_ff    <= length_high_in;
         bytes_left_ff     <= bytes_left_in;
         record_matches_ff <= record_matches_in;
      end
   end

   always_comb begin
      phase_in          = phase_ff;
      length_high_in    = length_high_ff;
      bytes_left_in     = bytes_left_ff;
      record_matches_in = record_matches_ff;
      res_valid         = 1'b0;
      res               = '0;
      rearm             = 1'b0;
      if (step_en) begin
         unique case (phase_ff)
            PH_TAG: begin
               if (!tag_ok) begin
                  res_valid  = 1'b1;
                  res.done_res = 1'b1;
                  res.status = ST_INVALID;
                  rearm      = end_of_buffer;
                  phase_in   = PH_IGNORE;
               end else begin
                  record_matches_in = (stream_byte == cfg.target_tag);
                  if (end_of_buffer) begin
                     res_valid    = 1'b1;
                     res.done_res = 1'b1;
                     res.status   = ST_TRUNCATED;
                     rearm        = 1'b1;
                  end else begin
                     phase_in = PH_LEN_HI;
                  end
               end
            end
            PH_LEN_HI: begin
               length_high_in = stream_byte;
               if (end_of_buffer) begin
                  res_valid    = 1'b1;
                  res.done_res = 1'b1;
                  res.status   = ST_TRUNCATED;
                  rearm        = 1'b1;
               end else begin
                  phase_in = PH_LEN_LO;
               end
            end
            PH_LEN_LO: begin
               if (len == '0) begin
                  if (record_matches_ff) begin
                     res_valid    = 1'b1;
                     res.done_res = 1'b1;
                     res.status   = ST_OK;
                     rearm        = end_of_buffer;
                     phase_in     = PH_IGNORE;
                  end else if (end_of_buffer) begin
                     res_valid    = 1'b1;
                     res.done_res = 1'b1;
                     res.status   = ST_NOT_FOUND;
                     rearm        = 1'b1;
                  end else begin
                     phase_in = PH_TAG;
                  end
               end else if (end_of_buffer) begin
                  res_valid    = 1'b1;
                  res.done_res = 1'b1;
                  res.status   = ST_TRUNCATED;
                  rearm        = 1'b1;
               end else begin
                  bytes_left_in = len;
                  phase_in      = PH_VALUE;
               end
            end
            PH_VALUE: begin
               bytes_left_in = left_dec;
               if (record_matches_ff) begin
                  res_valid      = 1'b1;
                  res.value_byte = stream_byte;
                  res.has_byte   = 1'b1;
                  if (left_dec == '0) begin
                     res.done_res = 1'b1;
                     res.status   = ST_OK;
                     rearm        = end_of_buffer;
                     phase_in     = PH_IGNORE;
                  end else if (end_of_buffer) begin
                     res.done_res = 1'b1;
                     res.status   = ST_TRUNCATED;
                     rearm        = 1'b1;
                  end
               end else if (left_dec == '0) begin
                  if (end_of_buffer) begin
                     res_valid    = 1'b1;
                     res.done_res = 1'b1;
                     res.status   = ST_NOT_FOUND;
                     rearm        = 1'b1;
                  end else begin
                     phase_in = PH_TAG;
                  end
               end else if (end_of_buffer) begin
                  res_valid    = 1'b1;
                  res.done_res = 1'b1;
                  res.status   = ST_TRUNCATED;
                  rearm        = 1'b1;
               end
            end
            default: begin
               rearm    = end_of_buffer;
               phase_in = PH_IGNORE;
            end
         endcase
         if (rearm) begin
            phase_in          = PH_TAG;
            length_high_in    = '0;
            bytes_left_in     = '0;
            record_matches_in = 1'b0;
         end
      end
   end

endmodule

FILE: src/tlv_tag_extractor_top.sv
// ----------------------------------------------------------------------------
// tlv_tag_extractor_top: TLV record search, one buffer byte per word
// Channel  | Signals                         | Content
// req      | req_tvalid/tready/tdata/tlast   | tdata = stream_byte, tlast = end_of_buffer
// rsp      | rsp_tvalid/tready/tdata/tuser/  | tdata = value_byte, tlast = done_res,
//          | tlast                           | tuser = {status, has_byte}
// csr      | APB psel/penable/pwrite/paddr/  | registers at 8*i, 64-bit data
//          | pwdata/prdata/pready            |
// One byte per cycle while rsp is not stalled: input register, parser logic, result register.
// A byte passes the input register, then the result register; results are zero or one per byte.
// Reset clears parser state, config registers and both pipeline valids; no clearing pass.
// A stalled rsp holds the result register; the input register still fills once.
// ----------------------------------------------------------------------------
module tlv_tag_extractor_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] stream_byte
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,   // [7:0] value_byte
   output logic [2:0]                        rsp_tuser,   // [0] has_byte, [2:1] status
   output logic                              rsp_tlast,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tlvx_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [tlvx_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tlvx_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import tlvx_pkg::*;

   tlvx_cfg_type      cfg;
   logic              in_valid_ff;
   logic              in_valid_in;
   logic [7:0]        in_byte_ff;
   logic              in_eob_ff;
   logic              out_valid_ff;
   logic              out_valid_in;
   tlvx_result_type   out_res_ff;
   logic              out_free;
   logic              step_en;
   logic              req_accept;
   logic              res_valid;
   tlvx_result_type   res;

   tlvx_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tlvx_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .step_en       (step_en),
      .stream_byte   (in_byte_ff),
      .end_of_buffer (in_eob_ff),
      .cfg           (cfg),
      .res_valid     (res_valid),
      .res           (res)
   );

   assign out_free   = !out_valid_ff || rsp_tready;
   assign step_en    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || step_en;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step_en) begin
         out_valid_in = res_valid;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_tdata;
         in_eob_ff  <= req_tlast;
      end
      if (step_en && res_valid) begin
         out_res_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_res_ff.value_byte;
   assign rsp_tlast  = out_res_ff.done_res;
   assign rsp_tuser  = {out_res_ff.status, out_res_ff.has_byte};

`ifndef SYNTHESIS
   a_no_byte_is_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast)
      else $error("result without a byte is not final");

   a_empty_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 8'd0)
      else $error("value byte nonzero without has_byte");

   a_status_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser[2:1] == ST_OK)
      else $error("status set on a non-final result");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input register lost a word under stall");
`endif

endmodule
